### rtl/core/rrf_pkg.sv
// Shared types and constants for the route redistribution filter.
// No dependencies; imported by the channel interfaces and all modules.
`default_nettype none
package rrf_pkg;

  localparam int DEFAULT_RULE_DEPTH = 16;

  // lanes per first-match group in the priority search
  localparam int LANE_GROUP = 16;
  localparam int LG_W       = 4;

  localparam logic [2:0] KIND_LABEL     = 3'd0;
  localparam logic [2:0] KIND_STATIC    = 3'd1;
  localparam logic [2:0] KIND_CONNECTED = 3'd2;
  localparam logic [2:0] KIND_ADDRESS   = 3'd3;
  localparam logic [2:0] KIND_DEFAULT   = 3'd4;

  // bit positions in route_origin
  localparam int ORIG_DYNAMIC   = 0;
  localparam int ORIG_STATIC    = 1;
  localparam int ORIG_CONNECTED = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic        negate;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [15:0] label;
  } rule_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] label;
    logic [5:0]  plen;
    logic [2:0]  origin;
  } query_t;

endpackage
`default_nettype wire

### rtl/core/rrf_if.sv
// Valid/ready channel interfaces for the filter's input and result streams.
// Depends on rrf_pkg only for the default table depth.
`default_nettype none
interface rrf_in_if
  import rrf_pkg::*;
#(
  parameter int IW = $clog2(DEFAULT_RULE_DEPTH)
);
  logic          valid;
  logic          ready;
  logic          action;
  logic [IW-1:0] rule_index;
  logic [2:0]    rule_kind;
  logic          rule_negate;
  logic [31:0]   address;
  logic [31:0]   rule_mask;
  logic [31:0]   rule_metric;
  logic [15:0]   label;
  logic [5:0]    prefix_length;
  logic [2:0]    route_origin;

  modport source (
    output valid, action, rule_index, rule_kind, rule_negate, address,
           rule_mask, rule_metric, label, prefix_length, route_origin,
    input  ready
  );
  modport sink (
    input  valid, action, rule_index, rule_kind, rule_negate, address,
           rule_mask, rule_metric, label, prefix_length, route_origin,
    output ready
  );
endinterface

interface rrf_out_if
  import rrf_pkg::*;
#(
  parameter int RW = $clog2(DEFAULT_RULE_DEPTH + 1)
);
  logic          valid;
  logic          ready;
  logic          redistribute;
  logic          metric_valid;
  logic [31:0]   metric;
  logic [RW-1:0] deciding_rule;

  modport source (
    output valid, redistribute, metric_valid, metric, deciding_rule,
    input  ready
  );
  modport sink (
    input  valid, redistribute, metric_valid, metric, deciding_rule,
    output ready
  );
endinterface
`default_nettype wire

### rtl/core/rrf_rule_lanes.sv
// Rule table lanes: one lane per entry holds the decoded rule and compares it
// against the current route in parallel. Depends on rrf_pkg.
`default_nettype none
module rrf_rule_lanes
  import rrf_pkg::*;
#(
  parameter int RULE_DEPTH = DEFAULT_RULE_DEPTH,
  parameter int IW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1,
  parameter int RW = $clog2(RULE_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [IW-1:0]         wr_idx,
  input  wire rule_t                 wr_rule,
  input  wire query_t                query,
  input  wire logic                  classify,
  input  wire logic [RW-1:0]         rules_in_use,
  output logic      [RULE_DEPTH-1:0] decide,
  output logic      [RULE_DEPTH-1:0] accept,
  output logic      [RULE_DEPTH-1:0] mval
);

  logic [2:0]  kind_r   [RULE_DEPTH];
  logic        neg_r    [RULE_DEPTH];
  logic [15:0] label_r  [RULE_DEPTH];
  logic [31:0] amask_r  [RULE_DEPTH];
  logic [31:0] mask_r   [RULE_DEPTH];
  logic [5:0]  mlen_r   [RULE_DEPTH];
  logic        zero_r   [RULE_DEPTH];

  // mask length: 32 minus trailing zeros, found by isolating the lowest set bit
  logic [31:0] low_bit;
  logic [4:0]  low_pos;
  logic [5:0]  wr_mlen;

  always_comb begin
    low_bit = wr_rule.mask & (~wr_rule.mask + 32'd1);
    low_pos = '0;
    for (int j = 0; j < 32; j++) begin
      if (low_bit[j]) low_pos = low_pos | 5'(j);
    end
    wr_mlen = (wr_rule.mask == 32'd0) ? 6'd0 : (6'd32 - {1'b0, low_pos});
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      kind_r[wr_idx]  <= wr_rule.kind;
      neg_r[wr_idx]   <= wr_rule.negate;
      label_r[wr_idx] <= wr_rule.label;
      amask_r[wr_idx] <= wr_rule.addr & wr_rule.mask;
      mask_r[wr_idx]  <= wr_rule.mask;
      mlen_r[wr_idx]  <= wr_mlen;
      zero_r[wr_idx]  <= (wr_rule.addr == 32'd0) && (wr_rule.mask == 32'd0);
    end
  end

  logic is_def;
  logic dyn;
  assign is_def = (query.addr == 32'd0) && (query.plen == 6'd0);
  assign dyn    = query.origin[ORIG_DYNAMIC];

  always_comb begin
    logic hit;
    logic stop;
    for (int i = 0; i < RULE_DEPTH; i++) begin
      hit  = 1'b0;
      stop = 1'b0;
      case (kind_r[i])
        KIND_LABEL:     hit = (query.label == label_r[i]);
        KIND_STATIC:    hit = !is_def && !dyn && query.origin[ORIG_STATIC];
        KIND_CONNECTED: hit = !is_def && !dyn && query.origin[ORIG_CONNECTED];
        KIND_ADDRESS: begin
          if (!dyn) begin
            if (zero_r[i]) begin
              hit  = is_def;
              stop = !is_def;
            end else begin
              hit = ((query.addr & mask_r[i]) == amask_r[i]) &&
                    (query.plen >= mlen_r[i]);
            end
          end
        end
        KIND_DEFAULT:   hit = is_def;
        default:        hit = 1'b0;
      endcase
      decide[i] = classify && (RW'(i) < rules_in_use) && (hit || stop);
      accept[i] = hit && !neg_r[i];
      mval[i]   = hit;
    end
  end

endmodule
`default_nettype wire

### rtl/core/route_redistribution_filter_unit.sv
// Top level of the route redistribution filter: pipeline control, first-match
// search and metric memory. Depends on rrf_pkg, rrf_if and rrf_rule_lanes.
//
//  channel | modport           | moves
//  in_ch   | rrf_in_if.sink    | classify or rule-write transactions
//  out_ch  | rrf_out_if.source | one result per input transaction
//  cfg_*   | write only        | rules_in_use register
//
// One transaction per cycle while out_ch does not stall; a result passes the
// input register, parallel rule lanes, per-group first match, group pick,
// then the metric memory read into the output register.
// Reset clears the stage valid bits and rules_in_use; the rule table is
// left as is. A stall on out_ch backs up one stage per cycle, and in_ch.ready
// falls only once all stages are full.
`default_nettype none
module route_redistribution_filter_unit
  import rrf_pkg::*;
#(
  parameter int RULE_DEPTH = DEFAULT_RULE_DEPTH
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  rrf_in_if.sink                                        in_ch,
  rrf_out_if.source                                     out_ch,
  input  wire logic                                     cfg_we,
  input  wire logic [$clog2(RULE_DEPTH + 1)-1:0]        cfg_wdata
);

  localparam int IW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int RW = $clog2(RULE_DEPTH + 1);
  localparam int NG = (RULE_DEPTH + LANE_GROUP - 1) / LANE_GROUP;

  logic [RW-1:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // stage valids and handshake
  logic s0_v_r, s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s0_v_nxt, s1_v_nxt, s2_v_nxt, s3_v_nxt, out_v_nxt;
  logic in_take, s1_take, s2_take, s3_take, out_load;

  assign out_load = s3_v_r && (!out_v_r || out_ch.ready);
  assign s3_take  = s2_v_r && (!s3_v_r || out_load);
  assign s2_take  = s1_v_r && (!s2_v_r || s3_take);
  assign s1_take  = s0_v_r && (!s1_v_r || s2_take);
  assign in_ch.ready = !s0_v_r || s1_take;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_comb begin
    s0_v_nxt  = in_take  ? 1'b1 : (s1_take  ? 1'b0 : s0_v_r);
    s1_v_nxt  = s1_take  ? 1'b1 : (s2_take  ? 1'b0 : s1_v_r);
    s2_v_nxt  = s2_take  ? 1'b1 : (s3_take  ? 1'b0 : s2_v_r);
    s3_v_nxt  = s3_take  ? 1'b1 : (out_load ? 1'b0 : s3_v_r);
    out_v_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s0_v_r  <= s0_v_nxt;
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // stage 0: input register
  logic          s0_act_r;
  logic [IW-1:0] s0_idx_r;
  rule_t         s0_rule_r;
  logic [31:0]   s0_metric_r;
  logic [5:0]    s0_plen_r;
  logic [2:0]    s0_orig_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_act_r         <= in_ch.action;
      s0_idx_r         <= in_ch.rule_index;
      s0_rule_r.kind   <= in_ch.rule_kind;
      s0_rule_r.negate <= in_ch.rule_negate;
      s0_rule_r.addr   <= in_ch.address;
      s0_rule_r.mask   <= in_ch.rule_mask;
      s0_rule_r.label  <= in_ch.label;
      s0_metric_r      <= in_ch.rule_metric;
      s0_plen_r        <= in_ch.prefix_length;
      s0_orig_r        <= in_ch.route_origin;
    end
  end

  query_t s0_query;
  logic   s0_wok;
  assign s0_query = '{addr: s0_rule_r.addr, label: s0_rule_r.label,
                      plen: s0_plen_r, origin: s0_orig_r};
  assign s0_wok   = {1'b0, s0_idx_r} < (IW + 1)'(RULE_DEPTH);

  logic [RULE_DEPTH-1:0] lane_decide, lane_accept, lane_mval;

  // table write commits as the write leaves stage 0, so every later route
  // sees it and every earlier one has already been compared
  rrf_rule_lanes #(
    .RULE_DEPTH (RULE_DEPTH),
    .IW         (IW),
    .RW         (RW)
  ) u_lanes (
    .clk          (clk),
    .wr_en        (s1_take && s0_act_r && s0_wok),
    .wr_idx       (s0_idx_r),
    .wr_rule      (s0_rule_r),
    .query        (s0_query),
    .classify     (!s0_act_r),
    .rules_in_use (cfg_r),
    .decide       (lane_decide),
    .accept       (lane_accept),
    .mval         (lane_mval)
  );

  // stage 1: lane decisions plus write data for the metric memory
  logic [RULE_DEPTH-1:0] s1_dec_r, s1_acc_r, s1_mv_r;
  logic                  s1_wr_r, s2_wr_r, s3_wr_r;
  logic [IW-1:0]         s1_widx_r, s2_widx_r, s3_widx_r;
  logic [31:0]           s1_wmet_r, s2_wmet_r, s3_wmet_r;

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_dec_r  <= lane_decide;
      s1_acc_r  <= lane_accept;
      s1_mv_r   <= lane_mval;
      s1_wr_r   <= s0_act_r && s0_wok;
      s1_widx_r <= s0_idx_r;
      s1_wmet_r <= s0_metric_r;
    end
  end

  // stage 2: first deciding lane inside each group
  logic            grp_found [NG];
  logic [LG_W-1:0] grp_loc   [NG];
  logic            grp_acc   [NG];
  logic            grp_mv    [NG];

  always_comb begin
    int lane;
    for (int g = 0; g < NG; g++) begin
      grp_found[g] = 1'b0;
      grp_loc[g]   = '0;
      grp_acc[g]   = 1'b0;
      grp_mv[g]    = 1'b0;
      for (int j = LANE_GROUP - 1; j >= 0; j--) begin
        lane = g * LANE_GROUP + j;
        if (lane < RULE_DEPTH) begin
          if (s1_dec_r[lane]) begin
            grp_found[g] = 1'b1;
            grp_loc[g]   = LG_W'(j);
            grp_acc[g]   = s1_acc_r[lane];
            grp_mv[g]    = s1_mv_r[lane];
          end
        end
      end
    end
  end

  logic            s2_found_r [NG];
  logic [LG_W-1:0] s2_loc_r   [NG];
  logic            s2_acc_r   [NG];
  logic            s2_mv_r    [NG];

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_found_r <= grp_found;
      s2_loc_r   <= grp_loc;
      s2_acc_r   <= grp_acc;
      s2_mv_r    <= grp_mv;
      s2_wr_r    <= s1_wr_r;
      s2_widx_r  <= s1_widx_r;
      s2_wmet_r  <= s1_wmet_r;
    end
  end

  // stage 3: first deciding group
  logic          pick_found, pick_acc, pick_mv;
  logic [IW-1:0] pick_idx;

  always_comb begin
    pick_found = 1'b0;
    pick_acc   = 1'b0;
    pick_mv    = 1'b0;
    pick_idx   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (s2_found_r[g]) begin
        pick_found = 1'b1;
        pick_acc   = s2_acc_r[g];
        pick_mv    = s2_mv_r[g];
        pick_idx   = IW'(g * LANE_GROUP + int'(s2_loc_r[g]));
      end
    end
  end

  logic          s3_found_r, s3_acc_r, s3_mv_r;
  logic [IW-1:0] s3_idx_r;

  always_ff @(posedge clk) begin
    if (s3_take) begin
      s3_found_r <= pick_found;
      s3_acc_r   <= pick_acc;
      s3_mv_r    <= pick_mv;
      s3_idx_r   <= pick_idx;
      s3_wr_r    <= s2_wr_r;
      s3_widx_r  <= s2_widx_r;
      s3_wmet_r  <= s2_wmet_r;
    end
  end

  // metric memory: written as a write leaves stage 3, read as a route does,
  // which keeps it in step with the lane table
  logic [31:0]   metric_mem [RULE_DEPTH];
  logic [31:0]   out_met_q_r;
  logic          out_acc_r, out_mv_r;
  logic [RW-1:0] out_rule_r;

  always_ff @(posedge clk) begin
    if (out_load && s3_wr_r) begin
      metric_mem[s3_widx_r] <= s3_wmet_r;
    end
    if (out_load) begin
      out_met_q_r <= metric_mem[s3_idx_r];
      out_acc_r   <= s3_found_r && s3_acc_r;
      out_mv_r    <= s3_found_r && s3_mv_r;
      out_rule_r  <= s3_found_r ? RW'(s3_idx_r) : RW'(RULE_DEPTH);
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.redistribute  = out_acc_r;
  assign out_ch.metric_valid  = out_mv_r;
  assign out_ch.metric        = out_mv_r ? out_met_q_r : 32'd0;
  assign out_ch.deciding_rule = out_rule_r;

`ifndef SYNTHESIS
  a_accept_has_metric: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_acc_r |-> out_mv_r)
    else $error("accepted route without a metric");

  a_metric_rule_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_mv_r |-> out_rule_r < RW'(RULE_DEPTH))
    else $error("metric reported without a deciding rule");

  a_out_fed_by_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s3_v_r))
    else $error("result appeared without a transaction in the last stage");

  a_read_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> $stable(out_ch.metric) && $stable(out_rule_r))
    else $error("result changed during a stall");

  a_stage0_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s0_v_r && !s1_take |=> s0_v_r)
    else $error("stage 0 transaction dropped while stalled");
`endif

endmodule
`default_nettype wire
